>>> design/ttp_pkg.sv
// Package with shared constants, command codes and types of the timeout timer pool.
package ttp_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIME_WIDTH = 32;
  localparam int CMD_W      = 3;
  localparam int INDEX_W    = 8;
  localparam int PERIOD_W   = 32;
  localparam int HANDLE_W   = 3;
  localparam int SLOT_W     = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_CREATE      = 3'd1,
    CMD_START       = 3'd2,
    CMD_POLL        = 3'd3,
    CMD_RELEASE_ALL = 3'd4
  } cmd_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_slot_t;

endpackage

>>> design/ttp_alloc_enc.sv
// Priority encoder that finds the lowest free timer slot.
module ttp_alloc_enc #(
  parameter int NumTimers = ttp_pkg::NUM_TIMERS
) (
  input  logic [NumTimers-1:0] alloc_i,
  output ttp_pkg::free_slot_t  free_o
);

  localparam int SlotW = ttp_pkg::SLOT_W;

  always_comb begin
    free_o = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!alloc_i[i]) begin
        free_o.found = 1'b1;
        free_o.slot  = SlotW'(i);
      end
    end
  end

endmodule

>>> design/timeout_timer_pool.sv
// Top level of the timeout timer pool: input register, execute logic, result register.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------------
//  command  | in        | start / busy              | cmd_i, timer_index_i, period_i
//  result   | out       | result_valid_o (strobe)   | status_o, handle_o, expired_o
//  config   | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (count_enable)
//
//  One command per cycle; busy stays low, each result passes through the input and result registers.
//  The rate is set by the single execute stage: lowest-free encode and one elapsed compare.
//  Reset clears the time counter and all allocation and running flags; counting is enabled.
//  Results are strobed for one cycle only; the receiver cannot stall.
module timeout_timer_pool #(
  parameter int NumTimers = ttp_pkg::NUM_TIMERS,
  parameter int TimeWidth = ttp_pkg::TIME_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ttp_pkg::CMD_W-1:0]    cmd_i,
  input  logic [ttp_pkg::INDEX_W-1:0]  timer_index_i,
  input  logic [ttp_pkg::PERIOD_W-1:0] period_i,
  output logic                         result_valid_o,
  output logic                         status_o,
  output logic [ttp_pkg::HANDLE_W-1:0] handle_o,
  output logic                         expired_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i
);

  localparam int IdxW    = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int IndexW  = ttp_pkg::INDEX_W;
  localparam int PeriodW = ttp_pkg::PERIOD_W;
  localparam int HandleW = ttp_pkg::HANDLE_W;
  localparam int CmpW    = (TimeWidth > PeriodW) ? TimeWidth : PeriodW;

  // input register
  logic                      in_vld_q;
  logic [ttp_pkg::CMD_W-1:0] cmd_q;
  logic [IndexW-1:0]         index_q;
  logic [PeriodW-1:0]        period_q;

  // state
  logic                 cnt_en_q;
  logic [TimeWidth-1:0] time_q, time_d;
  logic [NumTimers-1:0] alloc_q, alloc_d;
  logic [NumTimers-1:0] run_q, run_d;
  logic [TimeWidth-1:0] start_time_q [NumTimers];
  logic [PeriodW-1:0]   len_q        [NumTimers];

  // result register
  logic               res_vld_q;
  logic               status_q, status_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic               expired_q, expired_d;

  ttp_pkg::free_slot_t free;
  logic                in_range, usable, hit, wr_start;
  logic [IdxW-1:0]     sel;
  logic [TimeWidth-1:0] elapsed;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  ttp_alloc_enc #(
    .NumTimers(NumTimers)
  ) u_alloc_enc (
    .alloc_i(alloc_q),
    .free_o (free)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q    <= cmd_i;
      index_q  <= timer_index_i;
      period_q <= period_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cnt_en_q <= cfg_data_i;
    end
  end

  assign in_range = index_q < IndexW'(NumTimers);
  assign sel      = index_q[IdxW-1:0];
  assign usable   = in_range && alloc_q[sel] && cnt_en_q;
  assign elapsed  = time_q - start_time_q[sel];
  assign hit      = CmpW'(len_q[sel]) <= CmpW'(elapsed);

  always_comb begin
    time_d    = time_q;
    alloc_d   = alloc_q;
    run_d     = run_q;
    wr_start  = 1'b0;
    status_d  = ttp_pkg::STATUS_OK;
    handle_d  = '0;
    expired_d = 1'b0;
    case (cmd_q)
      ttp_pkg::CMD_TICK: begin
        if (cnt_en_q) begin
          time_d = time_q + TimeWidth'(1);
        end
      end
      ttp_pkg::CMD_CREATE: begin
        if (free.found) begin
          alloc_d[free.slot[IdxW-1:0]] = 1'b1;
          run_d[free.slot[IdxW-1:0]]   = 1'b0;
          handle_d = HandleW'(free.slot);
        end else begin
          status_d = ttp_pkg::STATUS_FAIL;
        end
      end
      ttp_pkg::CMD_START: begin
        if (usable) begin
          wr_start   = 1'b1;
          run_d[sel] = 1'b1;
        end else begin
          status_d = ttp_pkg::STATUS_FAIL;
        end
      end
      ttp_pkg::CMD_POLL: begin
        if (usable && run_q[sel]) begin
          if (hit) begin
            expired_d  = 1'b1;
            run_d[sel] = 1'b0;
          end
        end else begin
          status_d = ttp_pkg::STATUS_FAIL;
        end
      end
      ttp_pkg::CMD_RELEASE_ALL: begin
        alloc_d = '0;
        run_d   = '0;
      end
      default: begin
        status_d = ttp_pkg::STATUS_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      alloc_q   <= '0;
      run_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
      if (in_vld_q) begin
        time_q  <= time_d;
        alloc_q <= alloc_d;
        run_q   <= run_d;
      end
    end
  end

  // start time and length are only read for a running timer, which a start has written
  always_ff @(posedge clk_i) begin
    if (in_vld_q && wr_start) begin
      start_time_q[sel] <= time_q;
      len_q[sel]        <= period_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      status_q  <= status_d;
      handle_q  <= handle_d;
      expired_q <= expired_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign handle_o       = handle_q;
  assign expired_o      = expired_q;

endmodule

>>> design/ttp_checker.sv
// Port-level checker for the timeout timer pool, bound to the top level.
module ttp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [ttp_pkg::CMD_W-1:0]    cmd_i,
  input logic                         result_valid_o,
  input logic                         status_o,
  input logic [ttp_pkg::HANDLE_W-1:0] handle_o,
  input logic                         expired_o
);

  // every transaction gives exactly one result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_valid_o)
    else $error("missing result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without transaction");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> !expired_o && handle_o == '0)
    else $error("failure carries handle or expiry");

  a_tick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(start && !busy && cmd_i == ttp_pkg::CMD_TICK, 2)
      |-> status_o == ttp_pkg::STATUS_OK && !expired_o)
    else $error("tick reported failure");

endmodule

bind timeout_timer_pool ttp_checker u_ttp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .cmd_i         (cmd_i),
  .result_valid_o(result_valid_o),
  .status_o      (status_o),
  .handle_o      (handle_o),
  .expired_o     (expired_o)
);

>>> bench/tb_timeout_timer_pool.sv
// Self-checking testbench for the timeout timer pool: command stimulus, shadow model, result check.
module tb_timeout_timer_pool;
  import ttp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam int RESULT_LATENCY = 2;
  localparam int IDLE_LIMIT     = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] handle;
    logic                expired;
  } outcome_t;

  class pool_tracker;
    outcome_t            pending[$];
    logic                count_en;
    logic [TIME_WIDTH-1:0] time_now;
    bit                  alloc[NUM_TIMERS];
    bit                  run[NUM_TIMERS];
    logic [TIME_WIDTH-1:0] start_at[NUM_TIMERS];
    logic [PERIOD_W-1:0] timeout_len[NUM_TIMERS];
    int unsigned         mismatches;
    int unsigned         commands;
    int unsigned         results;
    int unsigned         expiries;
    int unsigned         failures;

    function new();
      count_en = 1'b1;
      time_now = '0;
      foreach (alloc[i]) begin
        alloc[i]       = 1'b0;
        run[i]         = 1'b0;
        start_at[i]    = '0;
        timeout_len[i] = '0;
      end
    endfunction

    function void set_enable(logic v);
      count_en = v;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    // Update the shadow pool for one accepted command and queue its outcome.
    function void accept_command(logic [CMD_W-1:0] c, logic [INDEX_W-1:0] ix,
                                 logic [PERIOD_W-1:0] p);
      outcome_t              o;
      bit                    in_range;
      bit                    usable;
      logic [TIME_WIDTH-1:0] elapsed;
      o        = '0;
      in_range = ix < NUM_TIMERS;
      usable   = in_range && alloc[in_range ? ix : 0] && count_en;
      commands++;
      case (c)
        CMD_TICK: begin
          if (count_en) time_now = time_now + 1'b1;
        end
        CMD_CREATE: begin
          o.status = STATUS_FAIL;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!alloc[i]) begin
              alloc[i]       = 1'b1;
              run[i]         = 1'b0;
              timeout_len[i] = '0;
              o.handle       = i[HANDLE_W-1:0];
              o.status       = STATUS_OK;
              break;
            end
          end
        end
        CMD_START: begin
          if (usable) begin
            start_at[ix]    = time_now;
            timeout_len[ix] = p;
            run[ix]         = 1'b1;
          end else begin
            o.status = STATUS_FAIL;
          end
        end
        CMD_POLL: begin
          if (usable && run[ix]) begin
            elapsed = time_now - start_at[ix];
            if (timeout_len[ix] <= elapsed) begin
              o.expired = 1'b1;
              run[ix]   = 1'b0;
            end
          end else begin
            o.status = STATUS_FAIL;
          end
        end
        CMD_RELEASE_ALL: begin
          foreach (alloc[i]) begin
            alloc[i]       = 1'b0;
            run[i]         = 1'b0;
            timeout_len[i] = '0;
          end
        end
        default: o.status = STATUS_FAIL;
      endcase
      if (o.expired) expiries++;
      if (o.status == STATUS_FAIL) failures++;
      pending.push_back(o);
    endfunction

    function void match_result(outcome_t got);
      outcome_t want;
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected result: status=%0d handle=%0d expired=%0d",
                   $time, got.status, got.handle, got.expired);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("[%0t] result %0d mismatch: expected status=%0d handle=%0d expired=%0d,",
                   $time, results, want.status, want.handle, want.expired);
          $display("    got status=%0d handle=%0d expired=%0d",
                   got.status, got.handle, got.expired);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i;
  logic [INDEX_W-1:0]  timer_index_i;
  logic [PERIOD_W-1:0] period_i;
  logic                result_valid_o;
  logic                status_o;
  logic [HANDLE_W-1:0] handle_o;
  logic                expired_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_data_i;

  pool_tracker tracker = new();
  int unsigned idle_cycles = 0;

  timeout_timer_pool uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i,
    .timer_index_i,
    .period_i,
    .result_valid_o,
    .status_o,
    .handle_o,
    .expired_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.set_enable(cfg_data_i);
      if (start && !busy) tracker.accept_command(cmd_i, timer_index_i, period_i);
      if (result_valid_o === 1'b1) tracker.match_result('{status_o, handle_o, expired_o});
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o === 1'b1 || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] ix,
                              input logic [PERIOD_W-1:0] p);
    start         <= 1'b1;
    cmd_i         <= c;
    timer_index_i <= ix;
    period_i      <= p;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input bit allow);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (allow) begin
      if (r >= 92) n = $urandom_range(8, 40);
      else if (r >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_count() != 0);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 85) return INDEX_W'($urandom_range(0, NUM_TIMERS - 1));
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PERIOD_W'($urandom_range(0, 15));
    if (r < 90) return PERIOD_W'($urandom_range(0, 300));
    return PERIOD_W'($urandom);
  endfunction

  task automatic random_burst(input int count);
    int                  r;
    logic [CMD_W-1:0]    c;
    logic [INDEX_W-1:0]  ix;
    logic [PERIOD_W-1:0] p;
    for (int i = 0; i < count; i++) begin
      r  = $urandom_range(0, 99);
      ix = INDEX_W'($urandom_range(0, 255));
      p  = PERIOD_W'($urandom);
      if (r < 35) c = CMD_TICK;
      else if (r < 47) c = CMD_CREATE;
      else if (r < 67) begin
        c  = CMD_START;
        ix = pick_index();
        p  = pick_period();
      end else if (r < 92) begin
        c  = CMD_POLL;
        ix = pick_index();
      end else if (r < 96) c = CMD_RELEASE_ALL;
      else c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      send_command(c, ix, p);
      if (i == count / 2) drain();
      else hold_off(i >= 40);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = '0;
    timer_index_i = '0;
    period_i      = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pool, fill, full pool, period extremes, restart, bad index and codes
    send_command(CMD_POLL, 8'd0, '0);
    send_command(CMD_START, 8'd0, 32'd5);
    for (int i = 0; i < NUM_TIMERS; i++) send_command(CMD_CREATE, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_CREATE, '0, '0);
    send_command(CMD_START, 8'd0, 32'd0);
    send_command(CMD_POLL, 8'd0, '0);
    send_command(CMD_POLL, 8'd0, '0);
    send_command(CMD_START, 8'd1, 32'd2);
    send_command(CMD_POLL, 8'd1, '0);
    send_command(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_START, 8'd1, 32'd2);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_POLL, 8'd1, '0);
    send_command(CMD_START, 8'd2, 32'hFFFF_FFFF);
    send_command(CMD_POLL, 8'd2, '0);
    send_command(CMD_START, 8'hFF, 32'd0);
    send_command(CMD_POLL, INDEX_W'(NUM_TIMERS), '0);
    send_command(CMD_UNUSED_HI, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_RELEASE_ALL, '0, '0);
    send_command(CMD_POLL, 8'd2, '0);

    // time base stopped: ticks ignored, start and poll refused
    write_enable(1'b0);
    send_command(CMD_CREATE, '0, '0);
    send_command(CMD_START, 8'd0, 32'd1);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_POLL, 8'd0, '0);
    random_burst(100);

    write_enable(1'b1);
    random_burst(200);
    write_enable(1'b0);
    random_burst(80);
    write_enable(1'b1);
    random_burst(200);

    drain();
    $display("Ran %0d commands, %0d results, %0d expiries, %0d failure statuses,",
             tracker.commands, tracker.results, tracker.expiries, tracker.failures);
    $display("with the time base switched off and on twice.");
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches,
               tracker.pending_count());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
